### src/lhc_pkg.sv
// Package for the LRU handle cache: sequencer states, list-operation
// contexts, action and status codes. No dependencies.
package lhc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_EV_RD,
    ST_EV_KEY,
    ST_UNL_RD,
    ST_UNL_WR,
    ST_APP_SET,
    ST_APP_LINK,
    ST_PUSH,
    ST_POP,
    ST_POP_NXT,
    ST_OPEN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    CTX_MOVE,
    CTX_INSERT,
    CTX_RELEASE,
    CTX_EVICT
  } ctx_t;

  localparam logic [1:0] ACT_APPEND = 2'd0;
  localparam logic [1:0] ACT_TRUNC  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [2:0] STS_HIT      = 3'd0;
  localparam logic [2:0] STS_INSERTED = 3'd1;
  localparam logic [2:0] STS_OPENFAIL = 3'd2;
  localparam logic [2:0] STS_WRFAIL   = 3'd3;
  localparam logic [2:0] STS_INVAL    = 3'd4;
  localparam logic [2:0] STS_ABSENT   = 3'd5;
  localparam logic [2:0] STS_CLEARED  = 3'd6;

endpackage

### src/lhc_key_mem.sv
// Key tag store of the LRU handle cache: one write port, one registered read.
// Depends on nothing.
module lhc_key_mem #(
  parameter int SLOTS = 8,
  parameter int KW    = 32,
  parameter int IW    = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] wa,
  input  logic [KW-1:0] wd,
  input  logic [IW-1:0] ra,
  output logic [KW-1:0] rd
);

  logic [KW-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

### src/lhc_link_mem.sv
// Link store of the LRU handle cache: previous and next link memories, each
// with one write port, read together at one address. Depends on nothing.
module lhc_link_mem #(
  parameter int SLOTS = 8,
  parameter int IW    = 3
) (
  input  logic        clk,
  input  logic [IW-1:0] ra,
  input  logic        prev_we,
  input  logic [IW-1:0] prev_wa,
  input  logic [IW:0] prev_wd,
  input  logic        next_we,
  input  logic [IW-1:0] next_wa,
  input  logic [IW:0] next_wd,
  output logic [IW:0] prev_rd,
  output logic [IW:0] next_rd
);

  logic [IW:0] prev_mem [SLOTS];
  logic [IW:0] next_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    prev_rd <= prev_mem[ra];
    next_rd <= next_mem[ra];
  end

endmodule

### src/lru_handle_cache_unit.sv
// Top level of the LRU handle cache: sequencer, slot bookkeeping and result
// register. Depends on lhc_pkg, lhc_key_mem and lhc_link_mem.
//
// Usage: one request enters on the in_ channel (action, key, open_ok,
// write_ok) and gives exactly one result on the out_ channel. A request is
// taken when in_valid is high and in_stall is low; a result is taken when
// out_valid is high and out_stall is low.
// The block works on one request at a time. A lookup reads the key memory
// one slot at a time, a scan state and a compare state per slot, and the
// list updates read link pairs from the link memories. A clear or an
// unused action goes straight to the result without a lookup.
// The result sits in an output register: the next request is accepted while
// a result waits, and its own result is held in the sequencer until the
// output register is free, so out_stall only delays, never drops.
// Reset (rst_n low, synchronous) empties the cache and the output register.
// No memory needs a clearing pass: a fill counter hands out never-used slots,
// valid bits mask unwritten keys, and only written links are ever used.
module lru_handle_cache_unit #(
  parameter int SLOTS    = 8,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_key,
  input  logic        in_open_ok,
  input  logic        in_write_ok,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [2:0]  out_slot,
  output logic        out_evicted,
  output logic [31:0] out_evicted_key,
  output logic [3:0]  out_entries
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam logic [IW:0] NIL = {1'b1, {IW{1'b0}}};

  lhc_pkg::state_t state_r, state_nxt;
  lhc_pkg::ctx_t   ctx_r, ctx_nxt;

  logic [IW-1:0] scan_r, scan_nxt;
  logic [IW-1:0] tgt_r, tgt_nxt;
  logic [KW-1:0] key_r, key_nxt;
  logic [1:0]    action_r, action_nxt;
  logic          open_ok_r, open_ok_nxt;
  logic          write_ok_r, write_ok_nxt;

  logic [2:0]    res_status_r, res_status_nxt;
  logic [IW-1:0] res_slot_r, res_slot_nxt;
  logic          res_evicted_r, res_evicted_nxt;
  logic [KW-1:0] res_ekey_r, res_ekey_nxt;

  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [IW:0]   free_head_r, free_head_nxt;
  logic [IW:0]   head_r, head_nxt;
  logic [IW:0]   tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] fresh_r, fresh_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r;
  logic [2:0]    out_slot_r;
  logic          out_evicted_r;
  logic [31:0]   out_ekey_r;
  logic [3:0]    out_entries_r;

  logic          key_we;
  logic [IW-1:0] key_ra;
  logic [KW-1:0] key_rd;
  logic [IW-1:0] link_ra;
  logic          prev_we, next_we;
  logic [IW-1:0] prev_wa, next_wa;
  logic [IW:0]   prev_wd, next_wd;
  logic [IW:0]   prev_rd, next_rd;

  logic          in_fire;
  logic          res_load;
  logic          match;
  logic          scan_last;
  logic          fh_fresh;
  logic [CW-1:0] fresh_inc;

  assign in_fire   = in_valid && (state_r == lhc_pkg::ST_IDLE);
  assign res_load  = (state_r == lhc_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  assign match     = valid_r[scan_r] && (key_rd == key_r);
  assign scan_last = (scan_r == IW'(SLOTS - 1));
  assign fh_fresh  = (CW'(free_head_r[IW-1:0]) == fresh_r);
  assign fresh_inc = fresh_r + CW'(1);
  assign key_ra    = (state_r == lhc_pkg::ST_EV_RD) ? tgt_r : scan_r;
  assign link_ra   = (state_r == lhc_pkg::ST_POP) ? free_head_r[IW-1:0] : tgt_r;

  lhc_key_mem #(.SLOTS(SLOTS), .KW(KW), .IW(IW)) u_key_mem (
    .clk (clk),
    .we  (key_we),
    .wa  (tgt_r),
    .wd  (key_r),
    .ra  (key_ra),
    .rd  (key_rd)
  );

  lhc_link_mem #(.SLOTS(SLOTS), .IW(IW)) u_link_mem (
    .clk     (clk),
    .ra      (link_ra),
    .prev_we (prev_we),
    .prev_wa (prev_wa),
    .prev_wd (prev_wd),
    .next_we (next_we),
    .next_wa (next_wa),
    .next_wd (next_wd),
    .prev_rd (prev_rd),
    .next_rd (next_rd)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lhc_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_action == lhc_pkg::ACT_APPEND || in_action == lhc_pkg::ACT_TRUNC) begin
            state_nxt = lhc_pkg::ST_SCAN;
          end else begin
            state_nxt = lhc_pkg::ST_DONE;
          end
        end
      end
      lhc_pkg::ST_SCAN: state_nxt = lhc_pkg::ST_CMP;
      lhc_pkg::ST_CMP: begin
        if (match) begin
          if (action_r == lhc_pkg::ACT_APPEND && tail_r == {1'b0, scan_r} && write_ok_r) begin
            state_nxt = lhc_pkg::ST_DONE;
          end else begin
            state_nxt = lhc_pkg::ST_UNL_RD;
          end
        end else if (!scan_last) begin
          state_nxt = lhc_pkg::ST_SCAN;
        end else if (action_r != lhc_pkg::ACT_APPEND) begin
          state_nxt = lhc_pkg::ST_DONE;
        end else if (!free_head_r[IW]) begin
          state_nxt = lhc_pkg::ST_POP;
        end else if (!head_r[IW]) begin
          state_nxt = lhc_pkg::ST_EV_RD;
        end else begin
          state_nxt = lhc_pkg::ST_DONE;
        end
      end
      lhc_pkg::ST_EV_RD:  state_nxt = lhc_pkg::ST_EV_KEY;
      lhc_pkg::ST_EV_KEY: state_nxt = lhc_pkg::ST_UNL_RD;
      lhc_pkg::ST_UNL_RD: state_nxt = lhc_pkg::ST_UNL_WR;
      lhc_pkg::ST_UNL_WR: begin
        state_nxt = (ctx_r == lhc_pkg::CTX_MOVE) ? lhc_pkg::ST_APP_SET : lhc_pkg::ST_PUSH;
      end
      lhc_pkg::ST_APP_SET:  state_nxt = lhc_pkg::ST_APP_LINK;
      lhc_pkg::ST_APP_LINK: state_nxt = write_ok_r ? lhc_pkg::ST_DONE : lhc_pkg::ST_UNL_RD;
      lhc_pkg::ST_PUSH: begin
        state_nxt = (ctx_r == lhc_pkg::CTX_EVICT) ? lhc_pkg::ST_POP : lhc_pkg::ST_DONE;
      end
      lhc_pkg::ST_POP: begin
        if (free_head_r[IW]) begin
          state_nxt = lhc_pkg::ST_DONE;
        end else if (fh_fresh) begin
          state_nxt = lhc_pkg::ST_OPEN;
        end else begin
          state_nxt = lhc_pkg::ST_POP_NXT;
        end
      end
      lhc_pkg::ST_POP_NXT: state_nxt = lhc_pkg::ST_OPEN;
      lhc_pkg::ST_OPEN:    state_nxt = open_ok_r ? lhc_pkg::ST_APP_SET : lhc_pkg::ST_DONE;
      lhc_pkg::ST_DONE: begin
        if (res_load) begin
          state_nxt = lhc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lhc_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls for each state.
  always_comb begin
    ctx_nxt         = ctx_r;
    scan_nxt        = scan_r;
    tgt_nxt         = tgt_r;
    key_nxt         = key_r;
    action_nxt      = action_r;
    open_ok_nxt     = open_ok_r;
    write_ok_nxt    = write_ok_r;
    res_status_nxt  = res_status_r;
    res_slot_nxt    = res_slot_r;
    res_evicted_nxt = res_evicted_r;
    res_ekey_nxt    = res_ekey_r;
    valid_nxt       = valid_r;
    free_head_nxt   = free_head_r;
    head_nxt        = head_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    fresh_nxt       = fresh_r;
    key_we          = 1'b0;
    prev_we         = 1'b0;
    prev_wa         = tgt_r;
    prev_wd         = tail_r;
    next_we         = 1'b0;
    next_wa         = tgt_r;
    next_wd         = NIL;
    unique case (state_r)
      lhc_pkg::ST_IDLE: begin
        if (in_fire) begin
          key_nxt         = KW'(in_key);
          action_nxt      = in_action;
          open_ok_nxt     = in_open_ok;
          write_ok_nxt    = in_write_ok;
          scan_nxt        = '0;
          res_status_nxt  = lhc_pkg::STS_ABSENT;
          res_slot_nxt    = '0;
          res_evicted_nxt = 1'b0;
          res_ekey_nxt    = '0;
          if (in_action == lhc_pkg::ACT_CLEAR) begin
            res_status_nxt = lhc_pkg::STS_CLEARED;
            valid_nxt      = '0;
            free_head_nxt  = '0;
            head_nxt       = NIL;
            tail_nxt       = NIL;
            count_nxt      = '0;
            fresh_nxt      = '0;
          end
        end
      end
      lhc_pkg::ST_CMP: begin
        if (match) begin
          tgt_nxt      = scan_r;
          res_slot_nxt = scan_r;
          if (action_r == lhc_pkg::ACT_TRUNC) begin
            res_status_nxt = lhc_pkg::STS_INVAL;
            ctx_nxt        = lhc_pkg::CTX_RELEASE;
          end else if (tail_r == {1'b0, scan_r}) begin
            // Already most recent: only a failed write changes anything.
            res_status_nxt = write_ok_r ? lhc_pkg::STS_HIT : lhc_pkg::STS_WRFAIL;
            ctx_nxt        = lhc_pkg::CTX_RELEASE;
          end else begin
            res_status_nxt = lhc_pkg::STS_HIT;
            ctx_nxt        = lhc_pkg::CTX_MOVE;
          end
        end else if (!scan_last) begin
          scan_nxt = scan_r + IW'(1);
        end else if (action_r == lhc_pkg::ACT_APPEND) begin
          tgt_nxt = head_r[IW-1:0];
          if (free_head_r[IW] && head_r[IW]) begin
            res_status_nxt = lhc_pkg::STS_OPENFAIL;
          end
        end
      end
      lhc_pkg::ST_EV_KEY: begin
        res_evicted_nxt = 1'b1;
        res_ekey_nxt    = key_rd;
        ctx_nxt         = lhc_pkg::CTX_EVICT;
      end
      lhc_pkg::ST_UNL_WR: begin
        if (!prev_rd[IW]) begin
          next_we = 1'b1;
          next_wa = prev_rd[IW-1:0];
          next_wd = next_rd;
        end else begin
          head_nxt = next_rd;
        end
        if (!next_rd[IW]) begin
          prev_we = 1'b1;
          prev_wa = next_rd[IW-1:0];
          prev_wd = prev_rd;
        end else begin
          tail_nxt = prev_rd;
        end
      end
      lhc_pkg::ST_APP_SET: begin
        prev_we = 1'b1;
        prev_wa = tgt_r;
        prev_wd = tail_r;
        next_we = 1'b1;
        next_wa = tgt_r;
        next_wd = NIL;
      end
      lhc_pkg::ST_APP_LINK: begin
        if (!tail_r[IW]) begin
          next_we = 1'b1;
          next_wa = tail_r[IW-1:0];
          next_wd = {1'b0, tgt_r};
        end else begin
          head_nxt = {1'b0, tgt_r};
        end
        tail_nxt = {1'b0, tgt_r};
        if (!write_ok_r) begin
          res_status_nxt = lhc_pkg::STS_WRFAIL;
          ctx_nxt        = lhc_pkg::CTX_RELEASE;
        end
      end
      lhc_pkg::ST_PUSH: begin
        next_we          = 1'b1;
        next_wa          = tgt_r;
        next_wd          = free_head_r;
        free_head_nxt    = {1'b0, tgt_r};
        valid_nxt[tgt_r] = 1'b0;
        count_nxt        = count_r - CW'(1);
      end
      lhc_pkg::ST_POP: begin
        if (free_head_r[IW]) begin
          res_status_nxt = lhc_pkg::STS_OPENFAIL;
        end else begin
          tgt_nxt      = free_head_r[IW-1:0];
          res_slot_nxt = free_head_r[IW-1:0];
          // A never-used slot chains to the next never-used one.
          if (fh_fresh) begin
            fresh_nxt     = fresh_inc;
            free_head_nxt = (fresh_inc == CW'(SLOTS)) ? NIL : {1'b0, IW'(fresh_inc)};
          end
        end
      end
      lhc_pkg::ST_POP_NXT: begin
        free_head_nxt = next_rd;
      end
      lhc_pkg::ST_OPEN: begin
        if (!open_ok_r) begin
          next_we        = 1'b1;
          next_wa        = tgt_r;
          next_wd        = free_head_r;
          free_head_nxt  = {1'b0, tgt_r};
          res_status_nxt = lhc_pkg::STS_OPENFAIL;
        end else begin
          key_we           = 1'b1;
          valid_nxt[tgt_r] = 1'b1;
          count_nxt        = count_r + CW'(1);
          res_status_nxt   = lhc_pkg::STS_INSERTED;
          ctx_nxt          = lhc_pkg::CTX_INSERT;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lhc_pkg::ST_IDLE;
      ctx_r       <= lhc_pkg::CTX_MOVE;
      valid_r     <= '0;
      free_head_r <= '0;
      head_r      <= NIL;
      tail_r      <= NIL;
      count_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      valid_r     <= valid_nxt;
      free_head_r <= free_head_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r        <= scan_nxt;
    tgt_r         <= tgt_nxt;
    key_r         <= key_nxt;
    action_r      <= action_nxt;
    open_ok_r     <= open_ok_nxt;
    write_ok_r    <= write_ok_nxt;
    res_status_r  <= res_status_nxt;
    res_slot_r    <= res_slot_nxt;
    res_evicted_r <= res_evicted_nxt;
    res_ekey_r    <= res_ekey_nxt;
    if (res_load) begin
      out_status_r  <= res_status_r;
      out_slot_r    <= 3'(res_slot_r);
      out_evicted_r <= res_evicted_r;
      out_ekey_r    <= 32'(res_ekey_r);
      out_entries_r <= 4'(count_r);
    end
  end

  assign in_stall        = (state_r != lhc_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_ekey_r;
  assign out_entries     = out_entries_r;

endmodule
